/* hdl/signed_number_to_digit_writes_defines.svh */
`ifndef SIGNED_NUMBER_TO_DIGIT_WRITES_DEFINES_SVH
`define SIGNED_NUMBER_TO_DIGIT_WRITES_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset
`define SNDW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante, outside reset
`define SNDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/sndw_pkg.sv */
`timescale 1ns / 1ps

package sndw_pkg;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Driver register addresses
  localparam logic [ADDR_W-1:0] ADDR_DECODE     = 4'd9;
  localparam logic [ADDR_W-1:0] ADDR_INTENSITY  = 4'd10;
  localparam logic [ADDR_W-1:0] ADDR_SCAN_LIMIT = 4'd11;
  localparam logic [ADDR_W-1:0] ADDR_POWER      = 4'd12;

  // Fixed settings of the init sequence
  localparam logic [DATA_W-1:0] DECODE_ALL      = 8'hFF;
  localparam logic [DATA_W-1:0] INTENSITY_LEVEL = 8'd8;
  localparam logic [DATA_W-1:0] POWER_ON        = 8'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUS  = 2'd2;

  // Configuration reset values
  localparam logic [3:0]        DIGITS_RST = 4'd8;
  localparam logic [DATA_W-1:0] BLANK_RST  = 8'd15;
  localparam logic [DATA_W-1:0] MINUS_RST  = 8'd10;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_USED,
    POS_ONE,
    POS_INC,
    POS_DEC
  } pos_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_DECODE,
    WR_SCAN,
    WR_INTENS,
    WR_POWER,
    WR_BLANK,
    WR_DIGIT,
    WR_SIGN
  } wsel_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    pos_op_e pos_op;
    wsel_e   wsel;
    logic    shift;
    logic    last;
    logic    ovf;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;
    logic pos_is_one;
    logic pos_at_max;
    logic rest_zero;
    logic neg;
  } sts_t;

endpackage

/* hdl/sndw_ctrl.sv */
`timescale 1ns / 1ps

module sndw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            operation_i,
  input  sndw_pkg::sts_t  sts_i,
  output sndw_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_BLANK = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] icnt_q, icnt_d;

  // Sequence the writes of one item
  always_comb begin
    state_d      = state_q;
    icnt_d       = icnt_q;
    cmd_o        = '0;
    cmd_o.pos_op = sndw_pkg::POS_HOLD;
    cmd_o.wsel   = sndw_pkg::WR_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          icnt_d = '0;
          if (operation_i) begin
            state_d = S_INIT;
          end else begin
            cmd_o.load   = 1'b1;
            cmd_o.pos_op = sndw_pkg::POS_USED;
            state_d      = S_BLANK;
          end
        end
      end
      S_INIT: begin
        icnt_d = icnt_q + 2'd1;
        case (icnt_q)
          2'd0: cmd_o.wsel = sndw_pkg::WR_DECODE;
          2'd1: cmd_o.wsel = sndw_pkg::WR_SCAN;
          2'd2: cmd_o.wsel = sndw_pkg::WR_INTENS;
          default: begin
            cmd_o.wsel = sndw_pkg::WR_POWER;
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_BLANK: begin
        cmd_o.wsel = sndw_pkg::WR_BLANK;
        if (sts_i.pos_is_one) begin
          cmd_o.pos_op = sndw_pkg::POS_ONE;
          state_d      = sts_i.conv_done ? S_DIGIT : S_WAIT;
        end else begin
          cmd_o.pos_op = sndw_pkg::POS_DEC;
        end
      end
      S_WAIT: begin
        if (sts_i.conv_done) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd_o.wsel   = sndw_pkg::WR_DIGIT;
        cmd_o.shift  = 1'b1;
        cmd_o.pos_op = sndw_pkg::POS_INC;
        if (sts_i.rest_zero) begin
          if (sts_i.neg && !sts_i.pos_at_max) begin
            state_d = S_SIGN;
          end else begin
            // sign dropped when the digits filled every position
            cmd_o.last = 1'b1;
            cmd_o.ovf  = sts_i.neg;
            state_d    = S_IDLE;
          end
        end else if (sts_i.pos_at_max) begin
          cmd_o.last = 1'b1;
          cmd_o.ovf  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SIGN: begin
        cmd_o.wsel = sndw_pkg::WR_SIGN;
        cmd_o.last = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      icnt_q  <= '0;
    end else begin
      state_q <= state_d;
      icnt_q  <= icnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* hdl/sndw_dp.sv */
`timescale 1ns / 1ps

module sndw_dp #(
  parameter int MAX_DIGITS   = 8,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sndw_pkg::cmd_t                       cmd_i,
  output sndw_pkg::sts_t                       sts_o,
  input  logic signed [NUMBER_WIDTH-1:0]       number_i,
  input  logic                                 cfg_we_i,
  input  logic [sndw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sndw_pkg::DATA_W-1:0]          cfg_data_i,
  output logic                                 result_valid_o,
  output logic [sndw_pkg::ADDR_W-1:0]          register_address_o,
  output logic [sndw_pkg::DATA_W-1:0]          data_value_o,
  output logic                                 last_o,
  output logic                                 overflow_o
);

  // Magnitude padded to an even width, two bits converted per cycle
  localparam int MAGW  = NUMBER_WIDTH + (NUMBER_WIDTH % 2);
  localparam int STEPS = MAGW / 2;
  localparam int NDIG  = (NUMBER_WIDTH * 30103) / 100000 + 1;
  localparam int BW    = 4 * NDIG;
  localparam int CW    = $clog2(STEPS + 1);
  localparam logic [sndw_pkg::ADDR_W-1:0] MAX_POS = sndw_pkg::ADDR_W'(MAX_DIGITS);

  logic [3:0]                  digits_q;
  logic [sndw_pkg::DATA_W-1:0] blank_q, minus_q;
  logic [sndw_pkg::ADDR_W-1:0] used, pos_q;
  logic [NUMBER_WIDTH-1:0]     raw, mag;
  logic [MAGW-1:0]             sh_q, sh_n;
  logic [BW-1:0]               bcd_q, bcd_n;
  logic [CW-1:0]               cnt_q;
  logic                        neg_q;
  logic [sndw_pkg::ADDR_W-1:0] addr_w;
  logic [sndw_pkg::DATA_W-1:0] data_w;
  logic                        valid_q, last_q, ovf_q;
  logic [sndw_pkg::ADDR_W-1:0] addr_q;
  logic [sndw_pkg::DATA_W-1:0] data_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= sndw_pkg::DIGITS_RST;
      blank_q  <= sndw_pkg::BLANK_RST;
      minus_q  <= sndw_pkg::MINUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sndw_pkg::CFG_DIGITS: digits_q <= cfg_data_i[3:0];
        sndw_pkg::CFG_BLANK:  blank_q  <= cfg_data_i;
        sndw_pkg::CFG_MINUS:  minus_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the digit count to the supported positions
  always_comb begin
    if (digits_q == 4'd0) begin
      used = 4'd1;
    end else if (digits_q > MAX_POS) begin
      used = MAX_POS;
    end else begin
      used = digits_q;
    end
  end

  // Form the magnitude of the incoming number
  assign raw = $unsigned(number_i);
  assign mag = raw[NUMBER_WIDTH-1] ? (~raw + NUMBER_WIDTH'(1)) : raw;

  // Two shift-and-add-3 steps of the binary to decimal converter
  always_comb begin
    bcd_n = bcd_q;
    sh_n  = sh_q;
    for (int it = 0; it < 2; it++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_n[4*d +: 4] >= 4'd5) begin
          bcd_n[4*d +: 4] = bcd_n[4*d +: 4] + 4'd3;
        end
      end
      {bcd_n, sh_n} = {bcd_n, sh_n} << 1;
    end
  end

  // Load, convert, then drop one digit per digit write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= CW'(STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bcd_q <= '0;
      sh_q  <= MAGW'(mag);
      neg_q <= raw[NUMBER_WIDTH-1];
    end else if (cnt_q != '0) begin
      bcd_q <= bcd_n;
      sh_q  <= sh_n;
    end else if (cmd_i.shift) begin
      bcd_q <= bcd_q >> 4;
    end
  end

  // Advance the register position
  always_ff @(posedge clk_i) begin
    case (cmd_i.pos_op)
      sndw_pkg::POS_USED: pos_q <= used;
      sndw_pkg::POS_ONE:  pos_q <= 4'd1;
      sndw_pkg::POS_INC:  pos_q <= pos_q + 4'd1;
      sndw_pkg::POS_DEC:  pos_q <= pos_q - 4'd1;
      default: ;
    endcase
  end

  assign sts_o.conv_done  = (cnt_q == '0);
  assign sts_o.pos_is_one = (pos_q == 4'd1);
  assign sts_o.pos_at_max = (pos_q == MAX_POS);
  assign sts_o.rest_zero  = (bcd_q[BW-1:4] == '0);
  assign sts_o.neg        = neg_q;

  // Select address and data of the current write
  always_comb begin
    addr_w = pos_q;
    data_w = '0;
    case (cmd_i.wsel)
      sndw_pkg::WR_DECODE: begin
        addr_w = sndw_pkg::ADDR_DECODE;
        data_w = sndw_pkg::DECODE_ALL;
      end
      sndw_pkg::WR_SCAN: begin
        addr_w = sndw_pkg::ADDR_SCAN_LIMIT;
        data_w = {4'd0, used - 4'd1};
      end
      sndw_pkg::WR_INTENS: begin
        addr_w = sndw_pkg::ADDR_INTENSITY;
        data_w = sndw_pkg::INTENSITY_LEVEL;
      end
      sndw_pkg::WR_POWER: begin
        addr_w = sndw_pkg::ADDR_POWER;
        data_w = sndw_pkg::POWER_ON;
      end
      sndw_pkg::WR_BLANK: data_w = blank_q;
      sndw_pkg::WR_DIGIT: data_w = {4'd0, bcd_q[3:0]};
      sndw_pkg::WR_SIGN:  data_w = minus_q;
      default: ;
    endcase
  end

  // Register the write for one cycle on the result ports
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.wsel != sndw_pkg::WR_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wsel != sndw_pkg::WR_NONE) begin
      addr_q <= addr_w;
      data_q <= data_w;
      last_q <= cmd_i.last;
      ovf_q  <= cmd_i.ovf;
    end
  end

  assign result_valid_o     = valid_q;
  assign register_address_o = addr_q;
  assign data_value_o       = data_q;
  assign last_o             = last_q;
  assign overflow_o         = ovf_q;

endmodule

/* hdl/signed_number_to_digit_writes.sv */
`timescale 1ns / 1ps
// Turns a display or init command into a run of display-driver register writes,
// one write per cycle on the result ports except while a display waits for the
// converter, each shown for exactly one cycle with result_valid_o; the receiver
// cannot stall, so it must take every write as it comes. An item is taken at a
// clock edge with start_i high and busy_o low; its first write is chosen in the
// controller state entered at that edge and then registered on the ports.
// Init gives four writes in consecutive cycles and holds busy_o high while it
// issues them. Display blanks the positions in use while a shift-and-add-3
// converter forms the decimal digits, two bits per cycle; the digit writes start
// once both the blanking and the conversion are done and then follow one per
// cycle, the minus sign last if a position is left for it. busy_o stays high
// until the last write is issued. The last write is on the ports in the first
// cycle with busy_o low, and the next item can be taken at the edge that ends it.
// Configuration is only to be written while busy_o is low; the user must keep to
// this, as the block itself does not enforce it.
`include "signed_number_to_digit_writes_defines.svh"

module signed_number_to_digit_writes #(
  parameter int MAX_DIGITS   = 8,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 operation_i,
  input  logic signed [NUMBER_WIDTH-1:0]       number_i,
  output logic                                 result_valid_o,
  output logic [sndw_pkg::ADDR_W-1:0]          register_address_o,
  output logic [sndw_pkg::DATA_W-1:0]          data_value_o,
  output logic                                 last_o,
  output logic                                 overflow_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sndw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sndw_pkg::DATA_W-1:0]          cfg_data_i
);

  sndw_pkg::cmd_t cmd;
  sndw_pkg::sts_t sts;
  logic           accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  sndw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  sndw_dp #(
    .MAX_DIGITS   (MAX_DIGITS),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .number_i           (number_i),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .register_address_o (register_address_o),
    .data_value_o       (data_value_o),
    .last_o             (last_o),
    .overflow_o         (overflow_o)
  );

  `SNDW_ASSERT_NEXT(a_start_busy, accept, busy_o)
  `SNDW_ASSERT_SAME(a_mid_run_busy, result_valid_o && !last_o, busy_o)
  `SNDW_ASSERT_SAME(a_ovf_on_last, result_valid_o && overflow_o, last_o)
  `SNDW_ASSERT_SAME(a_end_has_last, $fell(busy_o), result_valid_o && last_o)

endmodule
